### sv/btpp_pkg.sv
package btpp_pkg;

  localparam int MAX_DIFF = 2048;
  localparam int ROW_LEN  = MAX_DIFF + 1;
  localparam int IDX_W    = $clog2(ROW_LEN);
  localparam int WEIGHT_W = 12;
  localparam int SUM_W    = 16;
  localparam int RESULT_W = 16;
  localparam int SPAN_W   = ((IDX_W > WEIGHT_W) ? IDX_W : WEIGHT_W) + 1;
  localparam int ACC_W    = ((SUM_W > WEIGHT_W) ? SUM_W : WEIGHT_W) + 1;
  localparam int RESULT_MAX = (1 << (RESULT_W - 1)) - 1;

  typedef struct packed {
    logic             ok;
    logic [SUM_W-1:0] total;
  } entry_t;

  // best of the current choice and one shifted source plus the weight
  function automatic entry_t pick(entry_t cur, entry_t src, logic src_ok,
                                  logic [WEIGHT_W-1:0] w);
    logic [ACC_W-1:0] sum;
    logic [SUM_W-1:0] cand;
    entry_t           res;
    sum = ACC_W'(src.total) + ACC_W'(w);
    if (sum > ACC_W'({SUM_W{1'b1}})) begin
      cand = '1;
    end else begin
      cand = sum[SUM_W-1:0];
    end
    res = cur;
    if (src_ok && src.ok && (!cur.ok || cand > cur.total)) begin
      res.ok    = 1'b1;
      res.total = cand;
    end
    return res;
  endfunction

  function automatic logic [RESULT_W-1:0] answer(entry_t center, logic zero_seen);
    logic [SUM_W-1:0]    total;
    logic [ACC_W-1:0]    half;
    logic [RESULT_W-1:0] res;
    total = center.ok ? center.total : '0;
    half  = ACC_W'(total >> 1);
    if (total == '0) begin
      res = zero_seen ? '0 : '1;
    end else if (half > ACC_W'(RESULT_MAX)) begin
      res = RESULT_W'(RESULT_MAX);
    end else begin
      res = RESULT_W'(half);
    end
    return res;
  endfunction

endpackage

### sv/balanced_two_pile_partition_dp.sv
// Balanced two-pile partition. Items (weight, last) are taken by start while
// busy is low. The block keeps, per pile difference d, the best total weight
// placed on two piles; the row is symmetric in d, so only d = 0..MAX_DIFF is
// stored, in a ping-pong memory of two halves with two read ports.
// A nonzero weight sweeps the row once: each entry is read as d and d+w,
// then |d-w|, and is written to the other half, so busy stays high from
// the transfer until the last entry of the row has been written.
// A zero weight only marks that a zero item exists and starts no sweep.
// On the item with last set, done pulses for one cycle with pile_weight, in
// the cycle after the sweep ends, or the cycle after the transfer for a zero
// weight. pile_weight is half the best total at difference zero, 0 if only
// zero items balance, -1 if nothing balances. The receiver cannot stall;
// done is a single-cycle pulse. After rst no case is open; the first item of
// each case starts from a fresh row, read as reset contents without any
// clearing pass, so the block takes items right after reset.
module balanced_two_pile_partition_dp import btpp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [WEIGHT_W-1:0]        weight,
  input  logic                       last,
  output logic                       done,
  output logic signed [RESULT_W-1:0] pile_weight
);

  entry_t mem [2][ROW_LEN];

  logic                bank;
  logic                fresh;
  logic                issuing;
  logic                ph;
  logic [IDX_W-1:0]    idx;
  logic [WEIGHT_W-1:0] w_q;
  logic                last_q;
  logic                zero_seen;
  logic                case_open;
  entry_t              center;

  entry_t              rd0, rd1;
  logic                a0_zero, a1_zero;
  logic                hi_ok_q, lo_ok_q;
  entry_t              m1;
  logic [IDX_W-1:0]    d_q;
  logic                p2;

  logic [SPAN_W-1:0]   hi, lo;
  logic                hi_ok, lo_ok;
  logic [IDX_W-1:0]    ra0, ra1;
  entry_t              src0, src1, wdata;
  logic                accept, finish;

  assign accept = start && !busy;
  assign finish = p2 && (d_q == IDX_W'(MAX_DIFF));

  always_comb begin
    hi    = SPAN_W'(idx) + SPAN_W'(w_q);
    hi_ok = hi <= SPAN_W'(MAX_DIFF);
    if (SPAN_W'(idx) >= SPAN_W'(w_q)) begin
      lo = SPAN_W'(idx) - SPAN_W'(w_q);
    end else begin
      lo = SPAN_W'(w_q) - SPAN_W'(idx);
    end
    lo_ok = lo <= SPAN_W'(MAX_DIFF);
    // out-of-row sources read a harmless address and are masked later
    ra1 = hi_ok ? hi[IDX_W-1:0] : idx;
    ra0 = (ph && lo_ok) ? lo[IDX_W-1:0] : idx;
  end

  // a fresh row reads as valid zero at the centre, invalid elsewhere
  always_comb begin
    src0 = rd0;
    src1 = rd1;
    if (fresh) begin
      src0.ok    = a0_zero;
      src0.total = '0;
      src1.ok    = a1_zero;
      src1.total = '0;
    end
    wdata = pick(m1, src0, lo_ok_q, w_q);
  end

  always_ff @(posedge clk) begin
    rd0     <= mem[bank][ra0];
    rd1     <= mem[bank][ra1];
    if (p2) begin
      mem[!bank][d_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    a0_zero <= (ra0 == '0);
    a1_zero <= (ra1 == '0);
    hi_ok_q <= hi_ok;
    lo_ok_q <= lo_ok;
    if (issuing && !ph) begin
      d_q <= idx;
    end
    if (issuing && ph) begin
      m1 <= pick(src0, src1, hi_ok_q, w_q);
    end
    if (accept) begin
      w_q    <= weight;
      last_q <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issuing   <= 1'b0;
      ph        <= 1'b0;
      idx       <= '0;
      p2        <= 1'b0;
      done      <= 1'b0;
      bank      <= 1'b0;
      fresh     <= 1'b1;
      zero_seen <= 1'b0;
      case_open <= 1'b0;
      center    <= '{ok: 1'b1, total: '0};
    end else begin
      done <= 1'b0;
      p2   <= issuing && ph;
      if (issuing) begin
        ph <= !ph;
        if (ph) begin
          if (idx == IDX_W'(MAX_DIFF)) begin
            issuing <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      if (p2 && d_q == '0) begin
        center <= wdata;
      end
      if (finish) begin
        busy  <= 1'b0;
        bank  <= !bank;
        fresh <= 1'b0;
        done  <= last_q;
      end
      if (accept) begin
        case_open <= !last;
        if (!case_open) begin
          fresh     <= 1'b1;
          center    <= '{ok: 1'b1, total: '0};
          zero_seen <= (weight == '0);
        end else if (weight == '0) begin
          zero_seen <= 1'b1;
        end
        if (weight != '0) begin
          busy    <= 1'b1;
          issuing <= 1'b1;
          idx     <= '0;
          ph      <= 1'b0;
        end else begin
          done <= last;
        end
      end
    end
  end

  assign pile_weight = signed'(answer(center, zero_seen));

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while sweep in progress");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    p2 |-> busy) else $error("row write outside a sweep");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> !busy && (done == $past(last_q)))
    else $error("sweep end did not release the block");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && weight != '0) |=> busy && issuing && !ph && idx == '0)
    else $error("nonzero weight transfer did not start a sweep");

endmodule
